### sv/lprl_pkg.sv
// Package for the longest-prefix route lookup: types, constants and helpers.
`timescale 1ns / 1ps

package lprl_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int PORT_COUNT  = 16;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int PCMP_W      = 9;

  localparam logic [5:0]  MAX_PREFIX    = 6'd32;
  localparam logic [31:0] LOOPBACK_NET  = 32'h7F00_0000;
  localparam logic [5:0]  LOOPBACK_BITS = 6'd8;

  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [PCMP_W-1:0] pcmp_t;

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_APPEND = 2'd1,
    ACT_LOOKUP = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  typedef struct packed {
    action_t     action;
    logic [31:0] addr;
    logic [5:0]  prefix_len;
    logic [7:0]  path_len;
    logic [31:0] gateway;
    logic [3:0]  port_index;
    logic        dest_is_local;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic        deliver_local;
    logic [31:0] hop_addr;
    logic [3:0]  out_port;
    logic [5:0]  matched_len;
  } out_item_t;

  typedef struct packed {
    logic [31:0] prefix;
    logic [5:0]  len;
    logic [7:0]  path_len;
    logic [31:0] gateway;
    logic [3:0]  port;
  } route_t;

  typedef struct packed {
    logic clear;
    logic append;
    logic start;
    logic scan;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } status_t;

  // Network mask for a prefix length; 32 and above give all ones.
  function automatic logic [31:0] len_mask(input logic [5:0] len);
    logic [31:0] m;
    if (len >= MAX_PREFIX) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

endpackage

### sv/lprl_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module lprl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### sv/lprl_ctrl.sv
// Controller state machine: decodes items and sequences the table scan.
`timescale 1ns / 1ps

module lprl_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  lprl_pkg::action_t  action,
  input  lprl_pkg::status_t  status,
  output logic               in_ready,
  output lprl_pkg::cmd_t     cmd
);

  lprl_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lprl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lprl_pkg::ST_IDLE: begin
        if (in_valid && action == lprl_pkg::ACT_LOOKUP) begin
          state_nxt = lprl_pkg::ST_SCAN;
        end
      end
      lprl_pkg::ST_SCAN: begin
        if (status.scan_done) begin
          state_nxt = lprl_pkg::ST_FINISH;
        end
      end
      lprl_pkg::ST_FINISH: begin
        if (status.out_free) begin
          state_nxt = lprl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lprl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      lprl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (action)
            lprl_pkg::ACT_CLEAR:  cmd.clear  = 1'b1;
            lprl_pkg::ACT_APPEND: cmd.append = 1'b1;
            lprl_pkg::ACT_LOOKUP: cmd.start  = 1'b1;
            default: ;  // unused code: drop the item
          endcase
        end
      end
      lprl_pkg::ST_SCAN:   cmd.scan     = 1'b1;
      lprl_pkg::ST_FINISH: cmd.load_out = status.out_free;
      default: ;
    endcase
  end

endmodule

### sv/lprl_dp.sv
// Datapath: route table, scan counter, best-route tracking and result register.
`timescale 1ns / 1ps

module lprl_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lprl_pkg::cmd_t       cmd,
  input  lprl_pkg::in_item_t   in_data,
  input  logic                 out_ready,
  output lprl_pkg::status_t    status,
  output logic                 out_valid,
  output lprl_pkg::out_item_t  out_data
);

  lprl_pkg::cnt_t count_r, count_nxt;
  lprl_pkg::cnt_t rd_idx_r, rd_idx_nxt;
  logic           cmp_valid_r, cmp_valid_nxt;
  logic           out_valid_r, out_valid_nxt;

  logic [31:0] addr_r;
  logic        local_r;
  logic        best_found_r;
  logic [5:0]  best_len_r;
  logic [7:0]  best_path_r;
  logic [31:0] best_hop_r;
  logic [3:0]  best_port_r;
  lprl_pkg::out_item_t out_data_r;

  lprl_pkg::route_t wr_route;
  lprl_pkg::route_t rd_route;
  logic             wr_en;
  logic             rd_en;
  logic             match;
  logic             better;
  logic             hop_loop;

  // Append goes in only with room left and a valid port.
  assign wr_en = cmd.append
              && (count_r < lprl_pkg::cnt_t'(lprl_pkg::TABLE_DEPTH))
              && (lprl_pkg::pcmp_t'(in_data.port_index)
                  < lprl_pkg::pcmp_t'(lprl_pkg::PORT_COUNT));

  always_comb begin
    wr_route.prefix   = in_data.addr;
    wr_route.len      = (in_data.prefix_len > lprl_pkg::MAX_PREFIX)
                        ? lprl_pkg::MAX_PREFIX : in_data.prefix_len;
    wr_route.path_len = in_data.path_len;
    wr_route.gateway  = in_data.gateway;
    wr_route.port     = in_data.port_index;
  end

  assign rd_en = cmd.scan && (rd_idx_r < count_r);

  lprl_ram #(
    .WIDTH ($bits(lprl_pkg::route_t)),
    .DEPTH (lprl_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[lprl_pkg::IDX_W-1:0]),
    .wr_data (wr_route),
    .rd_en   (rd_en),
    .rd_addr (rd_idx_r[lprl_pkg::IDX_W-1:0]),
    .rd_data (rd_route)
  );

  always_comb begin
    count_nxt = count_r;
    if (cmd.clear) begin
      count_nxt = '0;
    end else if (wr_en) begin
      count_nxt = count_r + lprl_pkg::cnt_t'(1);
    end
  end

  always_comb begin
    rd_idx_nxt    = rd_idx_r;
    cmp_valid_nxt = 1'b0;
    if (cmd.start) begin
      rd_idx_nxt = '0;
    end else if (rd_en) begin
      rd_idx_nxt    = rd_idx_r + lprl_pkg::cnt_t'(1);
      cmp_valid_nxt = 1'b1;
    end
  end

  assign match  = ((addr_r & lprl_pkg::len_mask(rd_route.len)) == rd_route.prefix);
  // Longer prefix wins; equal length needs a strictly shorter path.
  assign better = !best_found_r
               || (rd_route.len > best_len_r)
               || ((rd_route.len == best_len_r) && (rd_route.path_len < best_path_r));

  assign hop_loop = ((best_hop_r & lprl_pkg::len_mask(lprl_pkg::LOOPBACK_BITS))
                     == lprl_pkg::LOOPBACK_NET);

  assign status.scan_done = !cmp_valid_r && (rd_idx_r == count_r);
  assign status.out_free  = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      rd_idx_r    <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      rd_idx_r    <= rd_idx_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      addr_r       <= in_data.addr;
      local_r      <= in_data.dest_is_local;
      best_found_r <= 1'b0;
    end else if (cmp_valid_r && match && better) begin
      best_found_r <= 1'b1;
      best_len_r   <= rd_route.len;
      best_path_r  <= rd_route.path_len;
      best_hop_r   <= rd_route.gateway;
      best_port_r  <= rd_route.port;
    end
    if (cmd.load_out) begin
      out_data_r.found         <= best_found_r;
      out_data_r.deliver_local <= best_found_r && (local_r || hop_loop);
      out_data_r.hop_addr      <= best_found_r ? best_hop_r  : '0;
      out_data_r.out_port      <= best_found_r ? best_port_r : '0;
      out_data_r.matched_len   <= best_found_r ? best_len_r  : '0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= lprl_pkg::cnt_t'(lprl_pkg::TABLE_DEPTH))
    else $error("route count beyond table depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan |-> rd_idx_r <= count_r)
    else $error("scan index past route count");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("result loaded over a waiting item");

  a_cmp_follows_read: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_valid_r |-> $past(rd_en))
    else $error("compare without a preceding table read");

endmodule

### sv/longest_prefix_route_lookup.sv
// Top level of the longest-prefix route lookup block.
`timescale 1ns / 1ps

// Route table of lprl_pkg::TABLE_DEPTH IPv4 routes held in one RAM. Clear and
// append items take effect as they are accepted. A lookup scans the stored
// routes one entry per cycle through the RAM's single registered read port.
// The result sits in an output register; a new item is accepted while it
// waits, but the next lookup holds after its scan, with in_ready low, until
// that result is taken. Table contents need no clearing after reset.
module longest_prefix_route_lookup (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  lprl_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output lprl_pkg::out_item_t  out_data
);

  lprl_pkg::cmd_t    cmd;
  lprl_pkg::status_t status;

  lprl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .action   (in_data.action),
    .status   (status),
    .in_ready (in_ready),
    .cmd      (cmd)
  );

  lprl_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_ready (out_ready),
    .status    (status),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
